>>> design/rprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rprt_pkg: shared definitions for the received packet range tracker
// Field widths, opcodes, the stored range entry and the compare unit flags.
// ----------------------------------------------------------------------------
package rprt_pkg;

	localparam int PN_W           = 62;
	localparam int OP_W           = 2;
	localparam int IDX_W          = 5;
	localparam int RC_W           = 6;
	localparam int DEF_MAX_RANGES = 32;

	// opcodes
	localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
	localparam logic [OP_W-1:0] OP_DISCARD = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	// one inclusive range
	typedef struct packed {
		logic [PN_W-1:0] low;
		logic [PN_W-1:0] high;
	} entry_t;

	// results of comparing an operand against one entry
	typedef struct packed {
		logic high_lt_pn;   // high < pn
		logic low_lt_pn;    // low < pn
		logic low_le_pn;    // low <= pn
		logic pn_next_low;  // pn + 1 == low (no wrap)
		logic high_next_pn; // high + 1 == pn (no wrap)
	} cmp_flags_t;

endpackage

>>> design/rprt_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rprt_cmp: shared compare unit
// Compares one operand against the low and high ends of one range entry.
// ----------------------------------------------------------------------------
module rprt_cmp import rprt_pkg::*; (
	input  logic [PN_W-1:0] pn,
	input  entry_t          ent,
	output cmp_flags_t      flags
);

	logic [PN_W:0] pn_inc;
	logic [PN_W:0] high_inc;

	// increments one bit wider so the top value never wraps to zero
	assign pn_inc   = {1'b0, pn} + {{PN_W{1'b0}}, 1'b1};
	assign high_inc = {1'b0, ent.high} + {{PN_W{1'b0}}, 1'b1};

	assign flags.high_lt_pn   = ent.high < pn;
	assign flags.low_lt_pn    = ent.low < pn;
	assign flags.low_le_pn    = ent.low <= pn;
	assign flags.pn_next_low  = pn_inc == {1'b0, ent.low};
	assign flags.high_next_pn = high_inc == {1'b0, pn};

endmodule

>>> design/rprt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rprt_store: range entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rprt_store import rprt_pkg::*; #(
	parameter int DEPTH = DEF_MAX_RANGES,
	parameter int AW    = $clog2(DEF_MAX_RANGES)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/received_packet_range_tracker.sv
`timescale 1ns / 1ps
// An add walks the stored ranges and may shift entries up or down, discard-below walks
// every stored range, read fetches one entry, and other opcodes and a discard below the
// current threshold go straight to the response.
// One item at a time: the next request is taken only once the sequencer returns to idle
// after the response loads. Reset clears the range count and the threshold at once; the
// range memory is not cleared, since only stored entries are read.
// ----------------------------------------------------------------------------
// received_packet_range_tracker: top level
// Sequencer walking a sorted range memory for add, discard-below and read,
// with a response register on the output side.
// ----------------------------------------------------------------------------
module received_packet_range_tracker import rprt_pkg::*; #(
	parameter int MAX_RANGES = DEF_MAX_RANGES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [OP_W-1:0]  opcode,
	input  logic [PN_W-1:0]  pkt_num,
	input  logic [IDX_W-1:0] entry_index,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic             status,
	output logic [PN_W-1:0]  largest_received,
	output logic [RC_W-1:0]  num_ranges,
	output logic             entry_valid,
	output logic [PN_W-1:0]  entry_low,
	output logic [PN_W-1:0]  entry_high
);

	localparam int AW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW  = $clog2(MAX_RANGES + 1);
	localparam int IXW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_SCAN_RD = 12'b0000_0000_0010,
		ST_SCAN_EV = 12'b0000_0000_0100,
		ST_SHUP_RD = 12'b0000_0000_1000,
		ST_SHUP_WR = 12'b0000_0001_0000,
		ST_SHDN_RD = 12'b0000_0010_0000,
		ST_SHDN_WR = 12'b0000_0100_0000,
		ST_DISC_RD = 12'b0000_1000_0000,
		ST_DISC_EV = 12'b0001_0000_0000,
		ST_READ_RD = 12'b0010_0000_0000,
		ST_READ_EV = 12'b0100_0000_0000,
		ST_RESP    = 12'b1000_0000_0000
	} state_t;

	state_t          state_q, state_d;
	logic [PN_W-1:0] pn_q, pn_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   k_q, k_d;
	logic [CW-1:0]   pos_q, pos_d;
	logic [CW-1:0]   wr_q, wr_d;
	logic [CW-1:0]   count_q, count_d;
	logic [PN_W-1:0] thr_q, thr_d;
	entry_t          prev_q, prev_d;
	logic            prev_adj_q, prev_adj_d;
	logic [PN_W-1:0] top_high_q;
	logic            res_status_q, res_status_d;
	logic            res_ev_q, res_ev_d;
	logic [PN_W-1:0] res_low_q, res_low_d;
	logic [PN_W-1:0] res_high_q, res_high_d;
	logic            rsp_load;

	logic             rsp_valid_q;
	logic             rsp_status_q;
	logic [PN_W-1:0]  rsp_largest_q;
	logic [RC_W-1:0]  rsp_count_q;
	logic             rsp_entry_valid_q;
	logic [PN_W-1:0]  rsp_low_q;
	logic [PN_W-1:0]  rsp_high_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        rd_data;

	logic [PN_W-1:0] cmp_pn;
	entry_t          cmp_ent;
	cmp_flags_t      flags;

	logic [CW-1:0] k_inc, k_dec, wr_inc, cnt_inc, cnt_dec;
	logic          cnt_full;

	// range memory
	rprt_store #(
		.DEPTH (MAX_RANGES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (rd_data)
	);

	// compare unit: threshold check when idle, stored entry otherwise
	assign cmp_pn      = (state_q == ST_IDLE) ? pkt_num : pn_q;
	assign cmp_ent.low  = (state_q == ST_IDLE) ? thr_q : rd_data.low;
	assign cmp_ent.high = (state_q == ST_IDLE) ? thr_q : rd_data.high;

	rprt_cmp u_cmp (
		.pn    (cmp_pn),
		.ent   (cmp_ent),
		.flags (flags)
	);

	// counter arithmetic
	assign k_inc    = k_q + CW'(1);
	assign k_dec    = k_q - CW'(1);
	assign wr_inc   = wr_q + CW'(1);
	assign cnt_inc  = count_q + CW'(1);
	assign cnt_dec  = count_q - CW'(1);
	assign cnt_full = count_q == CW'(MAX_RANGES);

	assign req_ready = state_q == ST_IDLE;

	// sequencer
	always_comb begin
		state_d      = state_q;
		pn_d         = pn_q;
		idx_d        = idx_q;
		k_d          = k_q;
		pos_d        = pos_q;
		wr_d         = wr_q;
		count_d      = count_q;
		thr_d        = thr_q;
		prev_d       = prev_q;
		prev_adj_d   = prev_adj_q;
		res_status_d = res_status_q;
		res_ev_d     = res_ev_q;
		res_low_d    = res_low_q;
		res_high_d   = res_high_q;
		rsp_load     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = k_q[AW-1:0];
		mem_wdata    = rd_data;
		mem_re       = 1'b0;
		mem_raddr    = k_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					pn_d         = pkt_num;
					idx_d        = AW'(entry_index);
					k_d          = '0;
					wr_d         = '0;
					res_status_d = 1'b0;
					res_ev_d     = 1'b0;
					res_low_d    = '0;
					res_high_d   = '0;
					case (opcode)
						OP_ADD: begin
							state_d = ST_SCAN_RD;
						end
						OP_DISCARD: begin
							if (flags.low_le_pn) begin
								thr_d   = pkt_num;
								state_d = ST_DISC_RD;
							end else begin
								state_d = ST_RESP;
							end
						end
						OP_READ: begin
							if (IXW'(entry_index) < IXW'(count_q)) begin
								state_d = ST_READ_RD;
							end else begin
								state_d = ST_RESP;
							end
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			// scan for the first range below the number
			ST_SCAN_RD: begin
				if (k_q == count_q) begin
					// number lies below every range
					if (count_q != '0 && prev_adj_q) begin
						mem_we         = 1'b1;
						mem_waddr      = cnt_dec[AW-1:0];
						mem_wdata.low  = pn_q;
						mem_wdata.high = prev_q.high;
					end else if (!cnt_full) begin
						mem_we         = 1'b1;
						mem_waddr      = count_q[AW-1:0];
						mem_wdata.low  = pn_q;
						mem_wdata.high = pn_q;
						count_d        = cnt_inc;
					end
					state_d = ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				if (!flags.high_lt_pn) begin
					if (flags.low_le_pn) begin
						res_status_d = 1'b1;
						state_d      = ST_RESP;
					end else begin
						prev_d     = rd_data;
						prev_adj_d = flags.pn_next_low;
						k_d        = k_inc;
						state_d    = ST_SCAN_RD;
					end
				end else if (k_q != '0 && prev_adj_q && flags.high_next_pn) begin
					// number bridges the gap: join the two ranges, then close the hole
					mem_we         = 1'b1;
					mem_waddr      = k_dec[AW-1:0];
					mem_wdata.low  = rd_data.low;
					mem_wdata.high = prev_q.high;
					k_d            = k_inc;
					state_d        = ST_SHDN_RD;
				end else if (k_q != '0 && prev_adj_q) begin
					mem_we         = 1'b1;
					mem_waddr      = k_dec[AW-1:0];
					mem_wdata.low  = pn_q;
					mem_wdata.high = prev_q.high;
					state_d        = ST_RESP;
				end else if (flags.high_next_pn) begin
					mem_we         = 1'b1;
					mem_wdata.low  = rd_data.low;
					mem_wdata.high = pn_q;
					state_d        = ST_RESP;
				end else begin
					// new range at this position; the lowest falls off when full
					pos_d   = k_q;
					k_d     = cnt_full ? CW'(MAX_RANGES - 1) : count_q;
					state_d = ST_SHUP_RD;
				end
			end
			// shift entries up to open a slot
			ST_SHUP_RD: begin
				if (k_q == pos_q) begin
					mem_we         = 1'b1;
					mem_wdata.low  = pn_q;
					mem_wdata.high = pn_q;
					if (!cnt_full) begin
						count_d = cnt_inc;
					end
					state_d = ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = k_dec[AW-1:0];
					state_d   = ST_SHUP_WR;
				end
			end
			ST_SHUP_WR: begin
				mem_we  = 1'b1;
				k_d     = k_dec;
				state_d = ST_SHUP_RD;
			end
			// shift entries down over a removed slot
			ST_SHDN_RD: begin
				if (k_q == count_q) begin
					count_d = cnt_dec;
					state_d = ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_SHDN_WR;
				end
			end
			ST_SHDN_WR: begin
				mem_we    = 1'b1;
				mem_waddr = k_dec[AW-1:0];
				k_d       = k_inc;
				state_d   = ST_SHDN_RD;
			end
			// compact the table against the new threshold
			ST_DISC_RD: begin
				if (k_q == count_q) begin
					count_d = wr_q;
					state_d = ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_DISC_EV;
				end
			end
			ST_DISC_EV: begin
				if (!flags.high_lt_pn) begin
					mem_we         = 1'b1;
					mem_waddr      = wr_q[AW-1:0];
					mem_wdata.low  = flags.low_lt_pn ? pn_q : rd_data.low;
					mem_wdata.high = rd_data.high;
					wr_d           = wr_inc;
				end
				k_d     = k_inc;
				state_d = ST_DISC_RD;
			end
			// single entry read
			ST_READ_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q;
				state_d   = ST_READ_EV;
			end
			ST_READ_EV: begin
				res_ev_d   = 1'b1;
				res_low_d  = rd_data.low;
				res_high_d = rd_data.high;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			thr_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			thr_q   <= thr_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		pn_q         <= pn_d;
		idx_q        <= idx_d;
		k_q          <= k_d;
		pos_q        <= pos_d;
		wr_q         <= wr_d;
		prev_q       <= prev_d;
		prev_adj_q   <= prev_adj_d;
		res_status_q <= res_status_d;
		res_ev_q     <= res_ev_d;
		res_low_q    <= res_low_d;
		res_high_q   <= res_high_d;
	end

	// mirror of the high end of entry 0
	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			top_high_q <= mem_wdata.high;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q      <= res_status_q;
			rsp_largest_q     <= (count_q != '0) ? top_high_q : '0;
			rsp_count_q       <= RC_W'(count_q);
			rsp_entry_valid_q <= res_ev_q;
			rsp_low_q         <= res_low_q;
			rsp_high_q        <= res_high_q;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign status           = rsp_status_q;
	assign largest_received = rsp_largest_q;
	assign num_ranges       = rsp_count_q;
	assign entry_valid      = rsp_entry_valid_q;
	assign entry_low        = rsp_low_q;
	assign entry_high       = rsp_high_q;

	// checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RANGES))
		else $error("range count above table size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while still busy");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESP))
		else $error("response raised outside the response state");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN_EV |-> k_q < count_q)
		else $error("scan index past stored ranges");

	a_dup_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q |-> !rsp_entry_valid_q)
		else $error("duplicate status together with entry data");

endmodule
